// ===== src/bbps_pkg.sv =====
`timescale 1ns / 1ps
package bbps_pkg;

	// configuration register indexes
	localparam logic [2:0] CfgSetpoint = 3'd0;
	localparam logic [2:0] CfgKp       = 3'd1;
	localparam logic [2:0] CfgKi       = 3'd2;
	localparam logic [2:0] CfgKd       = 3'd3;
	localparam logic [2:0] CfgPeriod   = 3'd4;
	localparam logic [2:0] CfgVelLimit = 3'd5;
	localparam logic [2:0] CfgAngleMin = 3'd6;
	localparam logic [2:0] CfgAngleMax = 3'd7;

	localparam logic [15:0] RstSetpoint = 16'd6912;
	localparam logic [15:0] RstKp       = 16'd384;
	localparam logic [15:0] RstKi       = 16'd13;
	localparam logic [15:0] RstKd       = 16'd16640;
	localparam logic [9:0]  RstPeriod   = 10'd70;
	localparam logic [15:0] RstVelLimit = 16'd9175;
	localparam logic [7:0]  RstAngleMin = 8'd30;
	localparam logic [7:0]  RstAngleMax = 8'd150;

	// divider: magnitude dividend, small positive divisor
	localparam int DivW = 33;
	localparam int DenW = 10;
	localparam int CntW = $clog2(DivW + 1);

	// dist = dur * 256 / 928 = dur * 8 / 29; angle = x * 180 / 300 = x * 3 / 5
	// both divides are a multiply by the rounded-up reciprocal and a shift:
	// ceil(2^32 / 29) exact for magnitudes below 2^27, ceil(2^29 / 5) below 2^26
	localparam logic [27:0] DistRecip = 28'd148102321;
	localparam logic [26:0] AngRecip  = 27'd107374183;

	typedef struct packed {
		logic [15:0] setpoint_q8;
		logic [15:0] kp_q8;
		logic [15:0] ki_q8;
		logic [15:0] kd_q8;
		logic [9:0]  period_ms;
		logic [15:0] vel_limit_q16;
		logic [7:0]  angle_min;
		logic [7:0]  angle_max;
	} cfg_t;

	typedef struct packed {
		logic            start;
		logic [DivW-1:0] num;
		logic [DenW-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ===== src/bbps_div.sv =====
`timescale 1ns / 1ps
module bbps_div import bbps_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  div_req_t        req,
	output div_stat_t       stat,
	output logic [DivW-1:0] quo
);

	logic [DivW-1:0] sh_q;
	logic [DenW-1:0] rem_q;
	logic [DenW-1:0] den_q;
	logic [CntW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [DenW:0]   trial;
	logic [DenW:0]   diff;
	logic            fits;

	// restoring division, one quotient bit per cycle
	always_comb begin
		trial = {rem_q, sh_q[DivW-1]};
		diff  = trial - {1'b0, den_q};
		fits  = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			sh_q   <= '0;
			rem_q  <= '0;
			den_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				sh_q   <= req.num;
				rem_q  <= '0;
				den_q  <= req.den;
				cnt_q  <= CntW'(DivW);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= fits ? diff[DenW-1:0] : trial[DenW-1:0];
				sh_q  <= {sh_q[DivW-2:0], fits};
				cnt_q <= cnt_q - CntW'(1);
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quo       = sh_q;

endmodule

// ===== src/bbps_core.sv =====
`timescale 1ns / 1ps
module bbps_core import bbps_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  cfg_t            cfg,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [15:0]     rise_ticks,
	input  logic [15:0]     fall_ticks,
	input  logic [7:0]      overflow_count,
	input  logic [31:0]     now_ms,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [7:0]      servo_angle,
	output logic            updated,
	output logic            glitch_corrected,
	output div_req_t        div_req,
	input  div_stat_t       div_stat,
	input  logic [DivW-1:0] div_quo
);

	typedef enum logic [4:0] {
		S_IDLE, S_CHECK, S_DIST0, S_DIST1, S_ERR, S_VEL0, S_VELS, S_VEL1,
		S_GL0, S_GL1, S_GL2, S_MP, S_MI, S_MD, S_SUM, S_ADDI, S_X3,
		S_ANG0, S_ANG1, S_CLAMP, S_DONE
	} state_t;

	state_t state_q;

	logic [15:0]        rise_q, fall_q;
	logic [7:0]         ovf_q;
	logic [31:0]        now_q;
	logic [31:0]        last_time_q;
	logic signed [23:0] prev_err_q;
	logic signed [16:0] prev_vel_q;
	logic signed [23:0] prev_pos_q;
	logic signed [31:0] integ_q;
	logic [7:0]         last_drive_q;

	logic signed [33:0] dnum_q;
	logic               neg_q;
	logic signed [23:0] dist_q, err_q, pos_q;
	logic signed [16:0] vel_q;
	logic signed [24:0] pterm_q;
	logic signed [26:0] acc_q;
	logic signed [27:0] ang_q;
	logic               glitch_q;
	logic signed [57:0] prod_s1;

	logic               out_valid_q, upd_q, gl_q;
	logic [7:0]         servo_q;
	logic [7:0]         res_angle_q;
	logic               res_upd_q;

	logic [9:0]         per_eff;
	logic [31:0]        elapsed;
	logic               due;
	logic [23:0]        ovf_term;
	logic signed [24:0] dur;
	logic signed [33:0] dneg;
	logic [DivW-1:0]    dmag;
	logic signed [23:0] qd24, dist_next;
	logic signed [16:0] qv, vel_next;
	logic signed [27:0] qa;
	logic signed [28:0] mul_a;
	logic signed [28:0] mul_b;
	logic signed [57:0] sh8, sh16, sh24, it8;
	logic signed [33:0] isum;
	logic               err_big;
	logic signed [27:0] amin, amax, ang_lo;
	logic [7:0]         ang_final;

	function automatic logic signed [57:0] shr_trunc(input logic signed [57:0] v,
		input int unsigned k);
		logic signed [57:0] bias;
		bias = v[57] ? ((58'sd1 <<< k) - 58'sd1) : 58'sd0;
		return (v + bias) >>> k;
	endfunction

	function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
		logic signed [23:0] r;
		if (v > 26'sd8388607) r = 24'sh7FFFFF;
		else if (v < -26'sd8388608) r = 24'sh800000;
		else r = v[23:0];
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		logic signed [31:0] r;
		if (v > 34'sd2147483647) r = 32'sh7FFFFFFF;
		else if (v < -34'sd2147483648) r = 32'sh80000000;
		else r = v[31:0];
		return r;
	endfunction

	always_comb begin
		per_eff  = (cfg.period_ms == 10'd0) ? 10'd1 : cfg.period_ms;
		elapsed  = now_q - last_time_q;
		due      = elapsed > {22'd0, per_eff};
		ovf_term = {ovf_q, 16'd0} - {16'd0, ovf_q};
		dur      = $signed({9'd0, fall_q}) - $signed({9'd0, rise_q})
		         + $signed({1'b0, ovf_term});

		dneg = -dnum_q;
		dmag = dnum_q[33] ? dneg[DivW-1:0] : dnum_q[DivW-1:0];

		// reciprocal products: distance takes bits above 2^32, angle above 2^29
		qd24      = $signed({1'b0, prod_s1[54:32]});
		dist_next = neg_q ? -qd24 : qd24;
		qv        = $signed({1'b0, div_quo[15:0]});
		vel_next  = neg_q ? -qv : qv;
		qa        = $signed({1'b0, prod_s1[55:29]});

		sh8  = shr_trunc(prod_s1, 8);
		sh16 = shr_trunc(prod_s1, 16);
		sh24 = shr_trunc(prod_s1, 24);
		it8  = shr_trunc(58'(integ_q), 8);
		isum = 34'(integ_q) + $signed(sh8[33:0]);
		err_big = (err_q > 24'sd256) || (err_q < -24'sd256);

		amin      = $signed({20'd0, cfg.angle_min});
		amax      = $signed({20'd0, cfg.angle_max});
		ang_lo    = (ang_q < amin) ? amin : ang_q;
		ang_final = (ang_lo > amax) ? cfg.angle_max : ang_lo[7:0];
	end

	// shared multiplier operands
	always_comb begin
		unique case (state_q)
			S_DIST0: begin
				mul_a = $signed({1'b0, DistRecip});
				mul_b = $signed({1'b0, dmag[27:0]});
			end
			S_GL0: begin
				mul_a = 29'(vel_q);
				mul_b = $signed({19'd0, per_eff});
			end
			S_MP: begin
				mul_a = $signed({13'd0, cfg.kp_q8});
				mul_b = 29'(err_q);
			end
			S_MI: begin
				mul_a = $signed({13'd0, cfg.ki_q8});
				mul_b = 29'(err_q);
			end
			S_MD: begin
				mul_a = $signed({13'd0, cfg.kd_q8});
				mul_b = 29'(vel_q);
			end
			S_ANG0: begin
				mul_a = $signed({2'b0, AngRecip});
				mul_b = $signed({1'b0, dmag[27:0]});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
	end

	always_comb begin
		div_req.num   = dmag;
		div_req.den   = per_eff;
		div_req.start = (state_q == S_VELS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			rise_q       <= '0;
			fall_q       <= '0;
			ovf_q        <= '0;
			now_q        <= '0;
			last_time_q  <= '0;
			prev_err_q   <= '0;
			prev_vel_q   <= 17'sd655;
			prev_pos_q   <= '0;
			integ_q      <= '0;
			last_drive_q <= '0;
			dnum_q       <= '0;
			neg_q        <= 1'b0;
			dist_q       <= '0;
			err_q        <= '0;
			pos_q        <= '0;
			vel_q        <= '0;
			pterm_q      <= '0;
			acc_q        <= '0;
			ang_q        <= '0;
			glitch_q     <= 1'b0;
			res_angle_q  <= '0;
			res_upd_q    <= 1'b0;
			out_valid_q  <= 1'b0;
			servo_q      <= '0;
			upd_q        <= 1'b0;
			gl_q         <= 1'b0;
		end else begin
			// S_DONE reloads the output register itself
			if (out_valid_q && out_ready && state_q != S_DONE) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						rise_q  <= rise_ticks;
						fall_q  <= fall_ticks;
						ovf_q   <= overflow_count;
						now_q   <= now_ms;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					glitch_q <= 1'b0;
					if (due) begin
						last_time_q <= now_q;
						dnum_q      <= 34'(dur) <<< 3;
						state_q     <= S_DIST0;
					end else begin
						res_angle_q <= last_drive_q;
						res_upd_q   <= 1'b0;
						state_q     <= S_DONE;
					end
				end
				S_DIST0: begin
					neg_q   <= dnum_q[33];
					state_q <= S_DIST1;
				end
				S_DIST1: begin
					dist_q  <= dist_next;
					state_q <= S_ERR;
				end
				S_ERR: begin
					err_q   <= sat24($signed({10'd0, cfg.setpoint_q8}) - 26'(dist_q));
					state_q <= S_VEL0;
				end
				S_VEL0: begin
					dnum_q  <= 34'(25'(err_q) - 25'(prev_err_q)) <<< 8;
					state_q <= S_VELS;
				end
				S_VELS: begin
					neg_q   <= dnum_q[33];
					state_q <= S_VEL1;
				end
				S_VEL1: begin
					if (div_stat.done) begin
						// magnitude above the limit in either direction is a glitch
						if (div_quo > {17'd0, cfg.vel_limit_q16}) begin
							vel_q    <= prev_vel_q;
							glitch_q <= 1'b1;
							state_q  <= S_GL0;
						end else begin
							vel_q   <= vel_next;
							pos_q   <= dist_q;
							state_q <= S_MP;
						end
					end
				end
				S_GL0: state_q <= S_GL1;
				S_GL1: begin
					pos_q   <= sat24(26'(prev_pos_q) + $signed(sh8[25:0]));
					state_q <= S_GL2;
				end
				S_GL2: begin
					err_q   <= sat24($signed({10'd0, cfg.setpoint_q8}) - 26'(pos_q));
					state_q <= S_MP;
				end
				S_MP: state_q <= S_MI;
				S_MI: begin
					pterm_q <= $signed(sh16[24:0]);
					state_q <= S_MD;
				end
				S_MD: begin
					integ_q <= err_big ? sat32(isum) : 32'sd0;
					state_q <= S_SUM;
				end
				S_SUM: begin
					acc_q   <= 27'(pterm_q) + 27'($signed(sh24[11:0])) + 27'sd150;
					state_q <= S_ADDI;
				end
				S_ADDI: begin
					acc_q   <= acc_q + 27'($signed(it8[23:0]));
					state_q <= S_X3;
				end
				S_X3: begin
					dnum_q  <= (34'(acc_q) <<< 1) + 34'(acc_q);
					state_q <= S_ANG0;
				end
				S_ANG0: begin
					neg_q   <= dnum_q[33];
					state_q <= S_ANG1;
				end
				S_ANG1: begin
					ang_q   <= neg_q ? -qa : qa;
					state_q <= S_CLAMP;
				end
				S_CLAMP: begin
					res_angle_q  <= ang_final;
					res_upd_q    <= 1'b1;
					last_drive_q <= ang_final;
					prev_err_q   <= err_q;
					prev_vel_q   <= vel_q;
					prev_pos_q   <= pos_q;
					state_q      <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						servo_q     <= res_angle_q;
						upd_q       <= res_upd_q;
						gl_q        <= glitch_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready         = (state_q == S_IDLE);
	assign out_valid        = out_valid_q;
	assign servo_angle      = servo_q;
	assign updated          = upd_q;
	assign glitch_corrected = gl_q;

`ifndef SYNTH
	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_stat.busy)
		else $error("divider started while busy");

	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == S_VEL1))
		else $error("divider result outside a wait state");

	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second request taken while busy");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && updated && (cfg.angle_min <= cfg.angle_max)
		|-> (servo_angle >= cfg.angle_min) && (servo_angle <= cfg.angle_max))
		else $error("drive angle outside limits");

	a_glitch_update: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && glitch_corrected |-> updated)
		else $error("glitch flag without update");
`endif

endmodule

// ===== src/ball_beam_pid_servo_drive.sv =====
`timescale 1ns / 1ps
// A request with no control update is answered without a control computation.
// An update's time is set mostly by one pass of the restoring divider (velocity), and
// glitch correction adds to it; distance and angle use multiplies.
// Throughput: one request at a time, the next taken the cycle after the result is
// posted; a finished result waits in the output register.
// Reset (arst_n low, asynchronous) restores the register defaults and state.
module ball_beam_pid_servo_drive import bbps_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] rise_ticks,
	input  logic [15:0] fall_ticks,
	input  logic [7:0]  overflow_count,
	input  logic [31:0] now_ms,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  servo_angle,
	output logic        updated,
	output logic        glitch_corrected
);

	cfg_t            cfg_q;
	div_req_t        div_req;
	div_stat_t       div_stat;
	logic [DivW-1:0] div_quo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.setpoint_q8   <= RstSetpoint;
			cfg_q.kp_q8         <= RstKp;
			cfg_q.ki_q8         <= RstKi;
			cfg_q.kd_q8         <= RstKd;
			cfg_q.period_ms     <= RstPeriod;
			cfg_q.vel_limit_q16 <= RstVelLimit;
			cfg_q.angle_min     <= RstAngleMin;
			cfg_q.angle_max     <= RstAngleMax;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CfgSetpoint: cfg_q.setpoint_q8   <= cfg_data;
				CfgKp:       cfg_q.kp_q8         <= cfg_data;
				CfgKi:       cfg_q.ki_q8         <= cfg_data;
				CfgKd:       cfg_q.kd_q8         <= cfg_data;
				CfgPeriod:   cfg_q.period_ms     <= cfg_data[9:0];
				CfgVelLimit: cfg_q.vel_limit_q16 <= cfg_data;
				CfgAngleMin: cfg_q.angle_min     <= cfg_data[7:0];
				CfgAngleMax: cfg_q.angle_max     <= cfg_data[7:0];
			endcase
		end
	end

	bbps_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.stat   (div_stat),
		.quo    (div_quo)
	);

	bbps_core u_core (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg_q),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.rise_ticks       (rise_ticks),
		.fall_ticks       (fall_ticks),
		.overflow_count   (overflow_count),
		.now_ms           (now_ms),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.servo_angle      (servo_angle),
		.updated          (updated),
		.glitch_corrected (glitch_corrected),
		.div_req          (div_req),
		.div_stat         (div_stat),
		.div_quo          (div_quo)
	);

endmodule
